>>> design/csrb_pkg.sv
// ----------------------------------------------------------------------------
// csrb_pkg
// Shared types, register indexes, decoder and reset values for the
// coprocessor system register bank.
// ----------------------------------------------------------------------------
package csrb_pkg;

	// Number of implemented registers and the width of an index into them.
	localparam int NUM_REGS = 40;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int DATA_W   = 32;

	// Field widths of one access.
	localparam int CRN_W = 4;
	localparam int OP1_W = 3;
	localparam int CRM_W = 4;
	localparam int OP2_W = 3;

	// Payload widths on the stream ports.
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 8;

	typedef logic [IDX_W-1:0] reg_idx_t;

	// Access kind.
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_UNDEF      = 3'd1,
		STAT_READ_ONLY  = 3'd2,
		STAT_BAD_CSEL   = 3'd3,
		STAT_BAD_TBCTL  = 3'd4,
		STAT_CSWITCH    = 3'd5
	} status_t;

	// Register indexes.
	localparam reg_idx_t IX_MIDR       = 6'd0;
	localparam reg_idx_t IX_CTR        = 6'd1;
	localparam reg_idx_t IX_MMFR0      = 6'd2;
	localparam reg_idx_t IX_MMFR1      = 6'd3;
	localparam reg_idx_t IX_CCSIDR     = 6'd4;
	localparam reg_idx_t IX_CLIDR      = 6'd5;
	localparam reg_idx_t IX_CSSELR     = 6'd6;
	localparam reg_idx_t IX_SCTLR      = 6'd7;
	localparam reg_idx_t IX_TTBR0      = 6'd8;
	localparam reg_idx_t IX_TTBR1      = 6'd9;
	localparam reg_idx_t IX_TTBCR      = 6'd10;
	localparam reg_idx_t IX_DACR       = 6'd11;
	localparam reg_idx_t IX_DFSR       = 6'd12;
	localparam reg_idx_t IX_IFSR       = 6'd13;
	localparam reg_idx_t IX_DFAR       = 6'd14;
	localparam reg_idx_t IX_IFAR       = 6'd15;
	localparam reg_idx_t IX_ICIALLU    = 6'd16;
	localparam reg_idx_t IX_ICIMVAU    = 6'd17;
	localparam reg_idx_t IX_CP15ISB    = 6'd18;
	localparam reg_idx_t IX_BPIALL     = 6'd19;
	localparam reg_idx_t IX_DCCMVAC    = 6'd20;
	localparam reg_idx_t IX_DCCSW      = 6'd21;
	localparam reg_idx_t IX_CP15DSB    = 6'd22;
	localparam reg_idx_t IX_DCCMVAU    = 6'd23;
	localparam reg_idx_t IX_DCCIMVAC   = 6'd24;
	localparam reg_idx_t IX_DCCISW     = 6'd25;
	localparam reg_idx_t IX_ITLBIALL   = 6'd26;
	localparam reg_idx_t IX_ITLBIMVA   = 6'd27;
	localparam reg_idx_t IX_ITLBIASID  = 6'd28;
	localparam reg_idx_t IX_DTLBIALL   = 6'd29;
	localparam reg_idx_t IX_DTLBIMVA   = 6'd30;
	localparam reg_idx_t IX_DTLBIASID  = 6'd31;
	localparam reg_idx_t IX_TLBIALL    = 6'd32;
	localparam reg_idx_t IX_PRRR       = 6'd33;
	localparam reg_idx_t IX_NMRR       = 6'd34;
	localparam reg_idx_t IX_FCSEIDR    = 6'd35;
	localparam reg_idx_t IX_CONTEXTIDR = 6'd36;
	localparam reg_idx_t IX_TPIDRURW   = 6'd37;
	localparam reg_idx_t IX_TPIDRURO   = 6'd38;
	localparam reg_idx_t IX_TPIDRPRW   = 6'd39;

	// Cache size ID words selected by the cache select register.
	localparam logic [DATA_W-1:0] CSIZE_WORD_0 = 32'hE007E01A;
	localparam logic [DATA_W-1:0] CSIZE_WORD_1 = 32'h2007E01A;
	localparam logic [DATA_W-1:0] CSIZE_WORD_2 = 32'hF03FE03A;

	// Control word bits that raise events.
	localparam int CTRL_MMU_BIT  = 0;
	localparam int CTRL_HVEC_BIT = 13;

	// Decoder result.
	typedef struct packed {
		logic     hit;
		reg_idx_t idx;
	} decode_t;

	// Maps an access tuple onto a register index.
	function automatic decode_t decode_tuple(
		input logic [CRN_W-1:0] crn,
		input logic [OP1_W-1:0] op1,
		input logic [CRM_W-1:0] crm,
		input logic [OP2_W-1:0] op2
	);
		decode_t d;
		d.hit = 1'b1;
		d.idx = IX_MIDR;
		case ({crn, op1, crm, op2})
			{4'd0, 3'd0, 4'd0, 3'd0}:   d.idx = IX_MIDR;
			{4'd0, 3'd0, 4'd0, 3'd1}:   d.idx = IX_CTR;
			{4'd0, 3'd0, 4'd1, 3'd4}:   d.idx = IX_MMFR0;
			{4'd0, 3'd0, 4'd1, 3'd5}:   d.idx = IX_MMFR1;
			{4'd0, 3'd1, 4'd0, 3'd0}:   d.idx = IX_CCSIDR;
			{4'd0, 3'd1, 4'd0, 3'd1}:   d.idx = IX_CLIDR;
			{4'd0, 3'd2, 4'd0, 3'd0}:   d.idx = IX_CSSELR;
			{4'd1, 3'd0, 4'd0, 3'd0}:   d.idx = IX_SCTLR;
			{4'd2, 3'd0, 4'd0, 3'd0}:   d.idx = IX_TTBR0;
			{4'd2, 3'd0, 4'd0, 3'd1}:   d.idx = IX_TTBR1;
			{4'd2, 3'd0, 4'd0, 3'd2}:   d.idx = IX_TTBCR;
			{4'd3, 3'd0, 4'd0, 3'd0}:   d.idx = IX_DACR;
			{4'd5, 3'd0, 4'd0, 3'd0}:   d.idx = IX_DFSR;
			{4'd5, 3'd0, 4'd0, 3'd1}:   d.idx = IX_IFSR;
			{4'd6, 3'd0, 4'd0, 3'd0}:   d.idx = IX_DFAR;
			{4'd6, 3'd0, 4'd0, 3'd2}:   d.idx = IX_IFAR;
			{4'd7, 3'd0, 4'd5, 3'd0}:   d.idx = IX_ICIALLU;
			{4'd7, 3'd0, 4'd5, 3'd1}:   d.idx = IX_ICIMVAU;
			{4'd7, 3'd0, 4'd5, 3'd4}:   d.idx = IX_CP15ISB;
			{4'd7, 3'd0, 4'd5, 3'd6}:   d.idx = IX_BPIALL;
			{4'd7, 3'd0, 4'd10, 3'd1}:  d.idx = IX_DCCMVAC;
			{4'd7, 3'd0, 4'd10, 3'd2}:  d.idx = IX_DCCSW;
			{4'd7, 3'd0, 4'd10, 3'd4}:  d.idx = IX_CP15DSB;
			{4'd7, 3'd0, 4'd11, 3'd1}:  d.idx = IX_DCCMVAU;
			{4'd7, 3'd0, 4'd14, 3'd1}:  d.idx = IX_DCCIMVAC;
			{4'd7, 3'd0, 4'd14, 3'd2}:  d.idx = IX_DCCISW;
			{4'd8, 3'd0, 4'd5, 3'd0}:   d.idx = IX_ITLBIALL;
			{4'd8, 3'd0, 4'd5, 3'd1}:   d.idx = IX_ITLBIMVA;
			{4'd8, 3'd0, 4'd5, 3'd2}:   d.idx = IX_ITLBIASID;
			{4'd8, 3'd0, 4'd6, 3'd0}:   d.idx = IX_DTLBIALL;
			{4'd8, 3'd0, 4'd6, 3'd1}:   d.idx = IX_DTLBIMVA;
			{4'd8, 3'd0, 4'd6, 3'd2}:   d.idx = IX_DTLBIASID;
			{4'd8, 3'd0, 4'd7, 3'd0}:   d.idx = IX_TLBIALL;
			{4'd10, 3'd0, 4'd2, 3'd0}:  d.idx = IX_PRRR;
			{4'd10, 3'd0, 4'd2, 3'd1}:  d.idx = IX_NMRR;
			{4'd13, 3'd0, 4'd0, 3'd0}:  d.idx = IX_FCSEIDR;
			{4'd13, 3'd0, 4'd0, 3'd1}:  d.idx = IX_CONTEXTIDR;
			{4'd13, 3'd0, 4'd0, 3'd2}:  d.idx = IX_TPIDRURW;
			{4'd13, 3'd0, 4'd0, 3'd3}:  d.idx = IX_TPIDRURO;
			{4'd13, 3'd0, 4'd0, 3'd4}:  d.idx = IX_TPIDRPRW;
			default:                    d.hit = 1'b0;
		endcase
		return d;
	endfunction

	// Value of a register after reset.
	function automatic logic [DATA_W-1:0] reg_reset_value(input reg_idx_t idx);
		logic [DATA_W-1:0] v;
		case (idx)
			IX_MIDR:   v = 32'h411FC083;
			IX_CTR:    v = 32'h80048004;
			IX_MMFR0:  v = 32'h31100003;
			IX_MMFR1:  v = 32'h20000000;
			IX_CCSIDR: v = CSIZE_WORD_0;
			IX_CLIDR:  v = 32'h0A000023;
			IX_SCTLR:  v = 32'h00C5187A;
			IX_DACR:   v = 32'h0000000F;
			IX_PRRR:   v = 32'h00098AA4;
			IX_NMRR:   v = 32'h44E048E0;
			default:   v = '0;
		endcase
		return v;
	endfunction

	// Cache size ID word for an accepted cache select value.
	function automatic logic [DATA_W-1:0] csize_word(input logic [1:0] sel);
		logic [DATA_W-1:0] v;
		case (sel)
			2'd0:    v = CSIZE_WORD_0;
			2'd1:    v = CSIZE_WORD_1;
			default: v = CSIZE_WORD_2;
		endcase
		return v;
	endfunction

endpackage

>>> design/csrb_ram.sv
// ----------------------------------------------------------------------------
// csrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/coprocessor_system_register_bank.sv
// ----------------------------------------------------------------------------
// coprocessor_system_register_bank
// System control coprocessor register file: decodes one access, reads or
// writes the addressed register and reports side-effect events.
// ----------------------------------------------------------------------------
// The 40 registers live in one RAM with a registered read. An item is
// accepted in the idle state and its register is read in that cycle; in the
// access state the result is formed, and once the output register can take
// it, any write is stored and the result is placed in the output register. A
// successful write to the cache select register then passes through a further
// state that loads the cache size ID word through the RAM's single write
// port. The input side accepts a new item while a result still waits in the
// output register. Reset values come from a table behind a valid bit per
// register, so no clearing pass is needed after reset.
module coprocessor_system_register_bank (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// primary_reg[3:0], opcode_one[6:4], secondary_reg[10:7], opcode_two[13:11],
	// write_value[45:14], zero fill[47:46]
	input  logic [csrb_pkg::S_TDATA_W-1:0]     s_tdata,
	// action[0]
	input  logic [csrb_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// read_data[31:0], previous_value[63:32]
	output logic [csrb_pkg::M_TDATA_W-1:0]     m_tdata,
	// status[2:0], mmu_enable_event[3], high_vector_event[4], table_base_event[5],
	// domain_change_event[6], mirror_event[7]
	output logic [csrb_pkg::M_TUSER_W-1:0]     m_tuser
);

	import csrb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_ACCESS = 3'b010,
		S_CSIZE  = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic              act_q;
	logic              hit_q;
	reg_idx_t          idx_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] csize_q;
	logic [NUM_REGS-1:0] valid_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic [CRN_W-1:0]  in_crn;
	logic [OP1_W-1:0]  in_op1;
	logic [CRM_W-1:0]  in_crm;
	logic [OP2_W-1:0]  in_op2;
	logic [DATA_W-1:0] in_val;
	decode_t           dec;
	logic              accept;

	reg_idx_t          ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              ram_we;
	reg_idx_t          ram_waddr;
	logic [DATA_W-1:0] ram_wdata;

	logic [DATA_W-1:0] cur;
	status_t           status;
	logic              write_ok;
	logic              out_free;
	logic              finish;
	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] prev;
	logic              ev_mmu, ev_hv, ev_tb, ev_dom, ev_mir;

	// Unpack the input item and decode its tuple.
	assign in_crn = s_tdata[3:0];
	assign in_op1 = s_tdata[6:4];
	assign in_crm = s_tdata[10:7];
	assign in_op2 = s_tdata[13:11];
	assign in_val = s_tdata[45:14];
	assign dec    = decode_tuple(in_crn, in_op1, in_crm, in_op2);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// The read is issued at acceptance and repeated while the result stalls.
	assign ram_raddr = (state_q == S_IDLE) ? dec.idx : idx_q;

	csrb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_REGS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Current register value; an entry never written reads its reset value.
	assign cur = valid_q[idx_q] ? ram_rdata : reg_reset_value(idx_q);

	// Access checks and write refusal rules.
	always_comb begin
		status = STAT_OK;
		if (!hit_q) begin
			status = STAT_UNDEF;
		end else if (act_q == ACT_WRITE) begin
			if (idx_q == IX_CCSIDR || idx_q == IX_CLIDR) begin
				status = STAT_READ_ONLY;
			end else if (idx_q == IX_CSSELR && val_q > 32'd2) begin
				status = STAT_BAD_CSEL;
			end else if (idx_q == IX_TTBCR && val_q[2:0] != 3'd0) begin
				status = STAT_BAD_TBCTL;
			end else if (idx_q == IX_FCSEIDR) begin
				status = STAT_CSWITCH;
			end
		end
	end

	assign write_ok = hit_q && (act_q == ACT_WRITE) && (status == STAT_OK);

	// Result fields and event flags.
	always_comb begin
		rd_data = (hit_q && act_q == ACT_READ) ? cur : '0;
		prev    = write_ok ? cur : '0;
		ev_mmu  = write_ok && idx_q == IX_SCTLR &&
		          !cur[CTRL_MMU_BIT] && val_q[CTRL_MMU_BIT];
		ev_hv   = write_ok && idx_q == IX_SCTLR &&
		          !cur[CTRL_HVEC_BIT] && val_q[CTRL_HVEC_BIT];
		ev_tb   = write_ok && idx_q == IX_TTBR0;
		ev_dom  = write_ok && idx_q == IX_DACR && (cur != val_q);
		ev_mir  = write_ok && (idx_q == IX_PRRR || idx_q == IX_NMRR ||
		          idx_q == IX_CONTEXTIDR || idx_q == IX_TPIDRURO);
	end

	// The result completes once the output register can take it.
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == S_ACCESS) && out_free;

	// RAM write: the addressed register, then the cache size ID if selected.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = val_q;
		case (state_q)
			S_ACCESS: begin
				ram_we = finish && write_ok;
			end
			S_CSIZE: begin
				ram_we    = 1'b1;
				ram_waddr = IX_CCSIDR;
				ram_wdata = csize_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_ACCESS;
				end
			end
			S_ACCESS: begin
				if (finish) begin
					state_d = (write_ok && idx_q == IX_CSSELR) ? S_CSIZE : S_IDLE;
				end
			end
			S_CSIZE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_tuser[0];
			hit_q <= dec.hit;
			idx_q <= dec.idx;
			val_q <= in_val;
		end
		if (finish) begin
			csize_q <= csize_word(val_q[1:0]);
		end
	end

	// One valid bit per register, set on its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {prev, rd_data};
			m_tuser_q <= {ev_mir, ev_dom, ev_tb, ev_hv, ev_mmu, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
